/* rtl/tlik_pkg.sv */
`timescale 1ns / 1ps
package tlik_pkg;

  // fixed formats
  localparam int ANG_FRAC = 24;
  localparam int ANG_W    = 34;
  localparam int VEC_W    = 37;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;

  // reset link lengths in tenths of a cm
  localparam int LINK_INNER_TENTHS = 58;
  localparam int LINK_OUTER_TENTHS = 76;
  localparam int LINK_MAX          = 32767;

  // ninety degrees in angle units
  localparam logic signed [ANG_W-1:0] ANG_RIGHT = 34'sd1509949440;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam int ATAN_LEN = 32;
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
    32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
  };

  // register map
  typedef enum logic [2:0] {
    REG_LINK_INNER      = 3'd0,
    REG_LINK_OUTER      = 3'd1,
    REG_SLOPE_JOINT_ONE = 3'd2,
    REG_BASE_JOINT_ONE  = 3'd3,
    REG_SLOPE_JOINT_TWO = 3'd4,
    REG_BASE_JOINT_TWO  = 3'd5,
    REG_OFFSET_JOINT_TWO = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [14:0] link_inner;
    logic [14:0] link_outer;
    logic [7:0]  slope_joint_one;
    logic [15:0] base_joint_one;
    logic [7:0]  slope_joint_two;
    logic [15:0] base_joint_two;
    logic [7:0]  offset_joint_two;
  } cfg_t;

  typedef struct packed {
    logic [14:0] target_x;
    logic [14:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] compare_joint_one;
    logic [15:0] compare_joint_two;
    logic        unreachable;
  } out_item_t;

  // values that ride along with the square roots
  typedef struct packed {
    logic              unreach;
    logic signed [33:0] m;
    logic signed [33:0] n;
    logic [14:0]       x;
    logic [14:0]       y;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [RAD_W-1:0] rad1;
    logic [RAD_W-1:0] rad2;
  } front_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] s1;
    logic [ROOT_W-1:0] s3;
  } root_t;

  typedef struct packed {
    logic                    unreach;
    logic signed [ANG_W-1:0] phi1;
    logic signed [ANG_W-1:0] th2;
    logic signed [ANG_W-1:0] phi2;
  } angle_t;

endpackage

/* rtl/tlik_chan_if.sv */
`timescale 1ns / 1ps
interface tlik_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tlik_front.sv */
`timescale 1ns / 1ps
module tlik_front (
  input  logic              clk,
  input  logic              rst,
  input  tlik_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlik_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tlik_pkg::front_t  out_data
);

  logic vld [4];
  logic en [4];

  // stage 1 registers
  logic [14:0] s1_x, s1_y;
  logic [29:0] s1_a2, s1_b2, s1_d2;
  logic [31:0] s1_r2, s1_s2;
  logic        s1_lzero;
  // stage 2 registers
  tlik_pkg::side_t s2_side;
  logic [29:0] s2_a2, s2_b2;
  logic [31:0] s2_r2, s2_mabs, s2_nabs;
  // stage 3 registers
  tlik_pkg::side_t s3_side;
  logic [63:0] s3_p1, s3_q1, s3_p2, s3_q2;

  logic [14:0] diff;
  logic [15:0] lsum;
  logic [29:0] xx, yy;
  logic signed [33:0] m_c, n_c, m_neg, n_neg;
  logic [61:0] ar;
  logic [59:0] ab;

  // ready chain, a stage moves when it is empty or its successor moves
  assign en[3] = !vld[3] || out_ready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
      vld[1] <= 1'b0;
      vld[2] <= 1'b0;
      vld[3] <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  // squares of the coordinates and link lengths
  always_comb begin
    diff = (cfg.link_inner > cfg.link_outer) ? cfg.link_inner - cfg.link_outer
                                             : cfg.link_outer - cfg.link_inner;
    lsum = {1'b0, cfg.link_inner} + {1'b0, cfg.link_outer};
    xx   = in_data.target_x * in_data.target_x;
    yy   = in_data.target_y * in_data.target_y;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_x     <= in_data.target_x;
      s1_y     <= in_data.target_y;
      s1_a2    <= cfg.link_inner * cfg.link_inner;
      s1_b2    <= cfg.link_outer * cfg.link_outer;
      s1_d2    <= diff * diff;
      s1_s2    <= lsum * lsum;
      s1_r2    <= {2'b00, xx} + {2'b00, yy};
      s1_lzero <= (cfg.link_inner == '0) || (cfg.link_outer == '0);
    end
  end

  // law of cosines numerators and workspace check
  always_comb begin
    m_c   = $signed({4'b0, s1_a2}) + $signed({2'b0, s1_r2}) - $signed({4'b0, s1_b2});
    n_c   = $signed({4'b0, s1_a2}) + $signed({4'b0, s1_b2}) - $signed({2'b0, s1_r2});
    m_neg = -m_c;
    n_neg = -n_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_side.unreach <= s1_lzero || (s1_r2 == '0) || (s1_r2 < {2'b00, s1_d2})
                         || (s1_r2 > s1_s2);
      s2_side.m <= m_c;
      s2_side.n <= n_c;
      s2_side.x <= s1_x;
      s2_side.y <= s1_y;
      s2_a2     <= s1_a2;
      s2_b2     <= s1_b2;
      s2_r2     <= s1_r2;
      s2_mabs   <= m_c[33] ? m_neg[31:0] : m_c[31:0];
      s2_nabs   <= n_c[33] ? n_neg[31:0] : n_c[31:0];
    end
  end

  // products under the square roots
  always_comb begin
    ar = s2_a2 * s2_r2;
    ab = s2_a2 * s2_b2;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_side <= s2_side;
      s3_p1   <= {ar, 2'b00};
      s3_p2   <= {2'b00, ab, 2'b00};
      s3_q1   <= s2_mabs * s2_mabs;
      s3_q2   <= s2_nabs * s2_nabs;
    end
  end

  // radicands, floored at zero
  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_data.side <= s3_side;
      out_data.rad1 <= (s3_p1 >= s3_q1) ? s3_p1 - s3_q1 : '0;
      out_data.rad2 <= (s3_p2 >= s3_q2) ? s3_p2 - s3_q2 : '0;
    end
  end

endmodule

/* rtl/tlik_sqrt.sv */
`timescale 1ns / 1ps
module tlik_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tlik_pkg::front_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tlik_pkg::root_t  out_data
);

  localparam int NSTEP = tlik_pkg::ROOT_W;

  typedef struct packed {
    logic [tlik_pkg::RAD_W-1:0]  rad;
    logic [tlik_pkg::ROOT_W-1:0] root;
    logic [32:0]                 rem;
  } sq_lane_t;

  typedef struct packed {
    tlik_pkg::side_t side;
    sq_lane_t        l1;
    sq_lane_t        l2;
  } sq_stage_t;

  // one result bit: bring down two radicand bits, try to subtract
  function automatic sq_lane_t sq_step(sq_lane_t cur);
    sq_lane_t    nxt;
    logic [34:0] pr;
    logic [34:0] trial;
    logic [34:0] dif;
    pr    = {cur.rem, cur.rad[63:62]};
    trial = {1'b0, cur.root, 2'b01};
    dif   = pr - trial;
    nxt.rad = {cur.rad[61:0], 2'b00};
    if (pr >= trial) begin
      nxt.rem  = dif[32:0];
      nxt.root = {cur.root[30:0], 1'b1};
    end else begin
      nxt.rem  = pr[32:0];
      nxt.root = {cur.root[30:0], 1'b0};
    end
    return nxt;
  endfunction

  sq_stage_t st_q [NSTEP];
  logic      vld_q [NSTEP];
  logic      en [NSTEP];
  sq_stage_t init;

  // start state of both lanes
  always_comb begin
    init.side    = in_data.side;
    init.l1.rad  = in_data.rad1;
    init.l1.root = '0;
    init.l1.rem  = '0;
    init.l2.rad  = in_data.rad2;
    init.l2.root = '0;
    init.l2.rem  = '0;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    sq_stage_t cur;
    logic      vin;

    if (k == NSTEP - 1) begin : g_last
      assign en[k] = !vld_q[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !vld_q[k] || en[k+1];
    end

    if (k == 0) begin : g_first
      assign cur = init;
      assign vin = in_valid;
    end else begin : g_next
      assign cur = st_q[k-1];
      assign vin = vld_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) vld_q[k] <= 1'b0;
      else if (en[k]) vld_q[k] <= vin;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_q[k].side <= cur.side;
        st_q[k].l1   <= sq_step(cur.l1);
        st_q[k].l2   <= sq_step(cur.l2);
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = vld_q[NSTEP-1];
  assign out_data.side = st_q[NSTEP-1].side;
  assign out_data.s1   = st_q[NSTEP-1].l1.root;
  assign out_data.s3   = st_q[NSTEP-1].l2.root;

endmodule

/* rtl/tlik_cordic.sv */
`timescale 1ns / 1ps
module tlik_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tlik_pkg::root_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tlik_pkg::angle_t out_data
);

  localparam int NORM_N = 6;
  localparam int NSTG   = 1 + NORM_N + CORDIC_STEPS;
  // shift per normalize stage and the bits that must be clear for it
  localparam int NORM_SH [NORM_N] = '{16, 8, 4, 2, 1, 1};
  localparam int NORM_TH [NORM_N] = '{16, 8, 4, 2, 1, 0};

  typedef struct packed {
    logic signed [tlik_pkg::VEC_W-1:0] u;
    logic signed [tlik_pkg::VEC_W-1:0] v;
    logic signed [tlik_pkg::ANG_W-1:0] z;
    logic                              swapped;
    logic                              zero;
  } cd_lane_t;

  typedef struct packed {
    logic           unreach;
    logic           x_zero;
    cd_lane_t [2:0] lane;
  } cd_stage_t;

  // move a vector with negative u into the first quadrant
  function automatic cd_lane_t setup(logic signed [34:0] u, logic [31:0] v);
    cd_lane_t           r;
    logic signed [34:0] neg;
    logic [32:0]        mu;
    logic [32:0]        mv;
    neg = -u;
    if (u[34]) begin
      mu        = {1'b0, v};
      mv        = neg[32:0];
      r.swapped = 1'b1;
    end else begin
      mu        = u[32:0];
      mv        = {1'b0, v};
      r.swapped = 1'b0;
    end
    r.u    = $signed({4'b0, mu});
    r.v    = $signed({4'b0, mv});
    r.z    = r.swapped ? tlik_pkg::ANG_RIGHT : '0;
    r.zero = ((mu | mv) == '0);
    return r;
  endfunction

  // one step of the leading-zero shift toward 2^32
  function automatic cd_lane_t norm(cd_lane_t l, int sh, int th);
    cd_lane_t    r;
    logic [32:0] w;
    r = l;
    w = l.u[32:0] | l.v[32:0];
    if ((w >> (32 - th)) == '0) begin
      r.u = l.u <<< sh;
      r.v = l.v <<< sh;
    end
    return r;
  endfunction

  // vectoring rotation, drives v toward zero
  function automatic cd_lane_t rot(cd_lane_t l, int i);
    cd_lane_t                          r;
    logic signed [tlik_pkg::VEC_W-1:0] du;
    logic signed [tlik_pkg::VEC_W-1:0] dv;
    logic signed [tlik_pkg::ANG_W-1:0] dz;
    r  = l;
    du = l.v >>> i;
    dv = l.u >>> i;
    dz = $signed({2'b00, tlik_pkg::ATAN_TAB[i]});
    if (!l.v[tlik_pkg::VEC_W-1]) begin
      r.u = l.u + du;
      r.v = l.v - dv;
      r.z = l.z + dz;
    end else begin
      r.u = l.u - du;
      r.v = l.v + dv;
      r.z = l.z - dz;
    end
    return r;
  endfunction

  function automatic logic signed [tlik_pkg::ANG_W-1:0] final_angle(cd_lane_t l);
    if (l.zero) return l.swapped ? tlik_pkg::ANG_RIGHT : '0;
    return l.z;
  endfunction

  cd_stage_t st_q [NSTG];
  logic      vld_q [NSTG];
  logic      en [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    cd_stage_t nxt;
    logic      vin;

    if (k == NSTG - 1) begin : g_last
      assign en[k] = !vld_q[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !vld_q[k] || en[k+1];
    end

    if (k == 0) begin : g_setup
      // shoulder (s1, m), elbow (s3, -n), base (y, x)
      assign vin = in_valid;
      always_comb begin
        nxt.unreach = in_data.side.unreach;
        nxt.x_zero  = (in_data.side.x == '0);
        nxt.lane[0] = setup({in_data.side.m[33], in_data.side.m}, in_data.s1);
        nxt.lane[1] = setup(35'sd0 - {in_data.side.n[33], in_data.side.n}, in_data.s3);
        nxt.lane[2] = setup($signed({20'b0, in_data.side.x}), {17'b0, in_data.side.y});
      end
    end else if (k <= NORM_N) begin : g_norm
      assign vin = vld_q[k-1];
      always_comb begin
        nxt = st_q[k-1];
        for (int j = 0; j < 3; j++) begin
          nxt.lane[j] = norm(st_q[k-1].lane[j], NORM_SH[k-1], NORM_TH[k-1]);
        end
      end
    end else begin : g_rot
      assign vin = vld_q[k-1];
      always_comb begin
        nxt = st_q[k-1];
        for (int j = 0; j < 3; j++) begin
          nxt.lane[j] = rot(st_q[k-1].lane[j], k - 1 - NORM_N);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld_q[k] <= 1'b0;
      else if (en[k]) vld_q[k] <= vin;
    end

    always_ff @(posedge clk) begin
      if (en[k]) st_q[k] <= nxt;
    end
  end

  assign in_ready         = en[0];
  assign out_valid        = vld_q[NSTG-1];
  assign out_data.unreach = st_q[NSTG-1].unreach;
  assign out_data.phi1    = final_angle(st_q[NSTG-1].lane[0]);
  assign out_data.th2     = final_angle(st_q[NSTG-1].lane[1]);
  // on the y axis the base angle is exactly ninety degrees
  assign out_data.phi2    = st_q[NSTG-1].x_zero ? tlik_pkg::ANG_RIGHT
                                                : final_angle(st_q[NSTG-1].lane[2]);

endmodule

/* rtl/tlik_map.sv */
`timescale 1ns / 1ps
module tlik_map (
  input  logic                clk,
  input  logic                rst,
  input  tlik_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlik_pkg::angle_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlik_pkg::out_item_t out_data
);

  logic vld [3];
  logic en [3];

  logic                    a_unreach;
  logic signed [tlik_pkg::ANG_W-1:0] a_t1, a_t2;
  logic                    b_unreach;
  logic signed [42:0]      b_v1, b_v2;

  function automatic logic [15:0] clamp(logic signed [42:0] val);
    if (val <= 0) return '0;
    if (val[42:40] != '0) return 16'hFFFF;
    return val[39:24];
  endfunction

  assign en[2] = !vld[2] || out_ready;
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
      vld[1] <= 1'b0;
      vld[2] <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // joint angles, joint two shifted by its offset
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_unreach <= in_data.unreach;
      a_t1      <= in_data.phi2 - in_data.phi1;
      a_t2      <= in_data.th2 + $signed({2'b00, cfg.offset_joint_two, 24'b0});
    end
  end

  // scale and add base, still with 24 fraction bits
  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_unreach <= a_unreach;
      b_v1 <= $signed({1'b0, cfg.slope_joint_one}) * a_t1
              + $signed({3'b000, cfg.base_joint_one, 24'b0});
      b_v2 <= $signed({1'b0, cfg.slope_joint_two}) * a_t2
              + $signed({3'b000, cfg.base_joint_two, 24'b0});
    end
  end

  // truncate and clamp into the output register
  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_data.unreachable       <= b_unreach;
      out_data.compare_joint_one <= b_unreach ? '0 : clamp(b_v1);
      out_data.compare_joint_two <= b_unreach ? '0 : clamp(b_v2);
    end
  end

endmodule

/* rtl/two_link_ik_servo_compare_top.sv */
`timescale 1ns / 1ps
// Two-link planar arm: target point in, servo compare values out.
// in_ch carries a request (target_x, target_y), both cm scaled by
// 2^COORD_FRAC_BITS. out_ch returns exactly one result per request, in order:
// compare_joint_one, compare_joint_two and the unreachable flag (compares are
// zero when the flag is set). The link lengths, slopes, bases and the joint
// two offset sit in APB registers at byte address 4*index; write them only
// while no request is in flight.
// Each request passes through the squares and products, the two bit-per-stage
// square roots, quadrant setup and normalization, the CORDIC rotations and
// the servo mapping. A new request is taken every cycle unless a receiver
// stall has filled the pipeline.
// Every stage holds a valid bit and moves when the stage after it is empty
// or moving, so a receiver stall holds results in place, bubbles close up,
// and in_ch.ready drops only once the pipeline is full.
// Reset clears all valid bits and loads the default register values.
module two_link_ik_servo_compare_top #(
  parameter int COORD_FRAC_BITS = 10,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  tlik_chan_if.sink   in_ch,
  tlik_chan_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned INNER_RAW = (tlik_pkg::LINK_INNER_TENTHS << COORD_FRAC_BITS) / 10;
  localparam int unsigned OUTER_RAW = (tlik_pkg::LINK_OUTER_TENTHS << COORD_FRAC_BITS) / 10;
  localparam logic [14:0] INNER_RST = (INNER_RAW > tlik_pkg::LINK_MAX) ? 15'h7FFF
                                                                        : 15'(INNER_RAW);
  localparam logic [14:0] OUTER_RST = (OUTER_RAW > tlik_pkg::LINK_MAX) ? 15'h7FFF
                                                                        : 15'(OUTER_RAW);
  localparam tlik_pkg::cfg_t CFG_RST = '{
    link_inner:       INNER_RST,
    link_outer:       OUTER_RST,
    slope_joint_one:  8'd32,
    base_joint_one:   16'd1330,
    slope_joint_two:  8'd32,
    base_joint_two:   16'd1200,
    offset_joint_two: 8'd90
  };

  tlik_pkg::cfg_t     cfg;
  tlik_pkg::reg_index_t ridx;

  logic             fr_valid, fr_ready;
  tlik_pkg::front_t fr_data;
  logic             sq_valid, sq_ready;
  tlik_pkg::root_t  sq_data;
  logic             cd_valid, cd_ready;
  tlik_pkg::angle_t cd_data;

  // register file
  assign ridx   = tlik_pkg::reg_index_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        tlik_pkg::REG_LINK_INNER:       cfg.link_inner       <= pwdata[14:0];
        tlik_pkg::REG_LINK_OUTER:       cfg.link_outer       <= pwdata[14:0];
        tlik_pkg::REG_SLOPE_JOINT_ONE:  cfg.slope_joint_one  <= pwdata[7:0];
        tlik_pkg::REG_BASE_JOINT_ONE:   cfg.base_joint_one   <= pwdata[15:0];
        tlik_pkg::REG_SLOPE_JOINT_TWO:  cfg.slope_joint_two  <= pwdata[7:0];
        tlik_pkg::REG_BASE_JOINT_TWO:   cfg.base_joint_two   <= pwdata[15:0];
        tlik_pkg::REG_OFFSET_JOINT_TWO: cfg.offset_joint_two <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (ridx)
      tlik_pkg::REG_LINK_INNER:       prdata = {17'b0, cfg.link_inner};
      tlik_pkg::REG_LINK_OUTER:       prdata = {17'b0, cfg.link_outer};
      tlik_pkg::REG_SLOPE_JOINT_ONE:  prdata = {24'b0, cfg.slope_joint_one};
      tlik_pkg::REG_BASE_JOINT_ONE:   prdata = {16'b0, cfg.base_joint_one};
      tlik_pkg::REG_SLOPE_JOINT_TWO:  prdata = {24'b0, cfg.slope_joint_two};
      tlik_pkg::REG_BASE_JOINT_TWO:   prdata = {16'b0, cfg.base_joint_two};
      tlik_pkg::REG_OFFSET_JOINT_TWO: prdata = {24'b0, cfg.offset_joint_two};
      default:                        prdata = '0;
    endcase
  end

  // datapath
  tlik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  tlik_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  tlik_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (cd_valid),
    .out_ready (cd_ready),
    .out_data  (cd_data)
  );

  tlik_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cd_valid),
    .in_ready  (cd_ready),
    .in_data   (cd_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule
